[sv/assert_macros.svh]
// Assertion helpers used by the RTL.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational check at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/rd_pkg.sv]
package rd_pkg;

    // Default operand width
    localparam int OPERAND_BITS = 28;

    // Microcode addressing
    localparam int UPC_W = 2;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t UPC_LOAD = 2'd0;
    localparam upc_t UPC_ITER = 2'd1;
    localparam upc_t UPC_EMIT = 2'd2;

    // Datapath operation of one microcode step
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ITER,
        OP_EMIT,
        OP_IDLE
    } op_t;

    // Jump condition; when true the sequencer goes to jump_pc, else next_pc
    typedef enum logic [1:0] {
        COND_NEVER,
        COND_NO_REQ,
        COND_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  jump_pc;
        upc_t  next_pc;
    } ctrl_word_t;

    // Control store: wait for a request, iterate once per quotient bit,
    // then hand the quotient to the output register.
    function automatic ctrl_word_t ucode(upc_t upc);
        ctrl_word_t w;
        unique case (upc)
            UPC_LOAD: w = '{op: OP_LOAD, cond: COND_NO_REQ,
                            jump_pc: UPC_LOAD, next_pc: UPC_ITER};
            UPC_ITER: w = '{op: OP_ITER, cond: COND_MORE,
                            jump_pc: UPC_ITER, next_pc: UPC_EMIT};
            UPC_EMIT: w = '{op: OP_EMIT, cond: COND_OUT_BUSY,
                            jump_pc: UPC_EMIT, next_pc: UPC_LOAD};
            default:  w = '{op: OP_IDLE, cond: COND_NEVER,
                            jump_pc: UPC_LOAD, next_pc: UPC_LOAD};
        endcase
        return w;
    endfunction

endpackage

[sv/rd_if.sv]
// Operand request channel
interface rd_in_if #(
    parameter int OPERAND_BITS = rd_pkg::OPERAND_BITS
) ();
    logic                    valid;
    logic                    ready;
    logic [OPERAND_BITS-1:0] dividend;
    logic [OPERAND_BITS-1:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink (input valid, input dividend, input divisor, output ready);
endinterface

// Quotient result channel
interface rd_out_if #(
    parameter int OPERAND_BITS = rd_pkg::OPERAND_BITS
) ();
    logic                    valid;
    logic                    ready;
    logic [OPERAND_BITS-1:0] quotient;

    modport source (output valid, output quotient, input ready);
    modport sink (input valid, input quotient, output ready);
endinterface

[sv/restoring_divider.sv]
// Unsigned restoring divider, OPERAND_BITS wide operands.
//
// request (sink): dividend and divisor; a request is taken when valid and
//   ready are both high. ready is high only while the sequencer waits at
//   its load step.
// result (source): truncated quotient, held in an output register until
//   taken. A zero divisor gives ones in bits 0 up to the dividend's
//   leading one (1 for a zero dividend).
//
// Sequence: after a request is taken the shared subtractor runs one
// shift-subtract step per quotient bit, then the write step fills the
// output register and result.valid rises; only then does the sequencer
// return to its load step and take the next request.
// A stalled receiver holds the quotient; the next request is still
// taken and computed, and waits at the write step until the output
// register frees up.
// Reset: rst_n (async, active low) returns the sequencer to the load
// step and empties the output register.
`include "assert_macros.svh"

module restoring_divider #(
    parameter int OPERAND_BITS = rd_pkg::OPERAND_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    rd_in_if.sink     request,
    rd_out_if.source  result
);

    localparam int CNT_W = $clog2(OPERAND_BITS);

    // Sequencer
    rd_pkg::upc_t       upc_reg;
    rd_pkg::upc_t       upc_next;
    rd_pkg::ctrl_word_t ctrl;
    logic               taken;

    // Datapath
    logic [OPERAND_BITS-1:0] rem_reg, rem_next;
    logic [OPERAND_BITS-1:0] quo_reg, quo_next;
    logic [OPERAND_BITS-1:0] dvd_reg, dvd_next;
    logic [OPERAND_BITS-1:0] dvs_reg, dvs_next;
    logic                    dvs_zero_reg, dvs_zero_next;
    logic                    seen_reg, seen_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [OPERAND_BITS:0]   trial;
    logic [OPERAND_BITS+1:0] diff;
    logic                    ge;
    logic                    qbit;

    // Output register
    logic [OPERAND_BITS-1:0] quotient_reg, quotient_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_free;
    logic                    out_load;

    // Control word fetch and jump decision
    always_comb
    begin
        ctrl     = rd_pkg::ucode(upc_reg);
        out_free = !out_valid_reg || result.ready;
        unique case (ctrl.cond)
            rd_pkg::COND_NEVER:    taken = 1'b0;
            rd_pkg::COND_NO_REQ:   taken = !request.valid;
            rd_pkg::COND_MORE:     taken = (count_reg != '0);
            rd_pkg::COND_OUT_BUSY: taken = !out_free;
            default:               taken = 1'b0;
        endcase
        upc_next = taken ? ctrl.jump_pc : ctrl.next_pc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= rd_pkg::UPC_LOAD;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign request.ready = (ctrl.op == rd_pkg::OP_LOAD);

    // Shift-subtract step: bring down the next dividend bit, try the divisor
    always_comb
    begin
        trial = {rem_reg, dvd_reg[OPERAND_BITS-1]};
        diff  = {1'b0, trial} - {2'b00, dvs_reg};
        ge    = !diff[OPERAND_BITS+1];
        // zero divisor: ones from the dividend's leading one down to bit 0
        qbit  = dvs_zero_reg ? (seen_reg | dvd_reg[OPERAND_BITS-1] | (count_reg == '0))
                             : ge;
    end

    // Datapath next state, steered by the control word
    always_comb
    begin
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dvd_next      = dvd_reg;
        dvs_next      = dvs_reg;
        dvs_zero_next = dvs_zero_reg;
        seen_next     = seen_reg;
        count_next    = count_reg;
        case (ctrl.op)
            rd_pkg::OP_LOAD:
            begin
                rem_next      = '0;
                quo_next      = '0;
                dvd_next      = request.dividend;
                dvs_next      = request.divisor;
                dvs_zero_next = (request.divisor == '0);
                seen_next     = 1'b0;
                count_next    = CNT_W'(OPERAND_BITS - 1);
            end
            rd_pkg::OP_ITER:
            begin
                rem_next   = ge ? diff[OPERAND_BITS-1:0] : trial[OPERAND_BITS-1:0];
                quo_next   = {quo_reg[OPERAND_BITS-2:0], qbit};
                dvd_next   = {dvd_reg[OPERAND_BITS-2:0], 1'b0};
                seen_next  = seen_reg | dvd_reg[OPERAND_BITS-1];
                count_next = count_reg - CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dvd_reg      <= dvd_next;
        dvs_reg      <= dvs_next;
        dvs_zero_reg <= dvs_zero_next;
        seen_reg     <= seen_next;
        count_reg    <= count_next;
    end

    // Output register
    always_comb
    begin
        out_load       = (ctrl.op == rd_pkg::OP_EMIT) && out_free;
        quotient_next  = out_load ? quo_reg : quotient_reg;
        out_valid_next = out_load ? 1'b1 : (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quotient_reg <= quotient_next;
    end

    assign result.valid    = out_valid_reg;
    assign result.quotient = quotient_reg;

    // Checks
    `ASSERT_NEXT(a_load_starts_iter, request.valid && request.ready,
        (upc_reg == rd_pkg::UPC_ITER) && (count_reg == CNT_W'(OPERAND_BITS - 1)),
        "accepted request did not start the iteration")
    `ASSERT_NEXT(a_iter_ends_emit, (ctrl.op == rd_pkg::OP_ITER) && (count_reg == '0),
        upc_reg == rd_pkg::UPC_EMIT, "last iteration did not go to the write step")
    `ASSERT_NEXT(a_emit_fills_out, out_load,
        out_valid_reg && (upc_reg == rd_pkg::UPC_LOAD),
        "write step did not fill the output register")

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    localparam int OPERAND_BITS = rd_pkg::OPERAND_BITS;

    typedef logic [OPERAND_BITS-1:0] operand_t;

    // One division request together with the quotient it must produce
    typedef struct {
        operand_t dividend;
        operand_t divisor;
        operand_t quotient;
    } division_t;

    localparam operand_t OPERAND_MAX = '1;
    localparam operand_t TOP_BIT = operand_t'(1) << (OPERAND_BITS - 1);
    localparam int DIV_LATENCY = OPERAND_BITS + 2;
    localparam int STALL_PERCENT = 12;
    localparam int IDLE_LIMIT = 1000;

    logic clk;
    logic rst_n;

    rd_in_if  request_if ();
    rd_out_if result_if ();

    restoring_divider dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_if),
        .result  (result_if)
    );

    division_t pending_divisions[$];
    int        error_count = 0;
    int        idle_cycles = 0;
    int        result_stall_left = 0;
    bit        no_idle = 1'b0;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Highest set bit; a zero value counts as position 0
    function automatic int top_bit_index(operand_t value);
        for (int pos = OPERAND_BITS - 1; pos > 0; pos--)
        begin
            if (value[pos])
            begin
                return pos;
            end
        end
        return 0;
    endfunction

    // Shift-subtract division, aligned on the leading ones of both operands
    function automatic operand_t restoring_quotient(operand_t dividend, operand_t divisor);
        logic [2*OPERAND_BITS-1:0] remainder;
        logic [2*OPERAND_BITS-1:0] shifted;
        operand_t                  quotient;
        int                        bit_pos;
        remainder = dividend;
        quotient  = '0;
        bit_pos   = top_bit_index(dividend) - top_bit_index(divisor);
        while (bit_pos >= 0)
        begin
            shifted = divisor;
            shifted = shifted << bit_pos;
            if (remainder >= shifted)
            begin
                remainder         = remainder - shifted;
                quotient[bit_pos] = 1'b1;
            end
            bit_pos--;
        end
        return quotient;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // After an optional idle gap, hold one request until the divider takes it
    task automatic send_division(input operand_t dividend, input operand_t divisor);
        int        gap;
        division_t entry;
        gap = 0;
        if (!no_idle)
        begin
            if ($urandom_range(19) == 0)
                gap = $urandom_range(DIV_LATENCY + 4, 1);
            else
            begin
                while ($urandom_range(99) < STALL_PERCENT)
                    gap++;
            end
        end
        if (gap > 0)
        begin
            request_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_if.valid    <= 1'b1;
        request_if.dividend <= dividend;
        request_if.divisor  <= divisor;
        do
            @(posedge clk);
        while (!request_if.ready);
        entry.dividend = dividend;
        entry.divisor  = divisor;
        entry.quotient = restoring_quotient(dividend, divisor);
        pending_divisions.push_back(entry);
    endtask

    // Drop valid and wait until every quotient has come back
    task automatic pause_until_drained();
        request_if.valid <= 1'b0;
        while (pending_divisions.size() != 0)
            @(posedge clk);
    endtask

    // Random width so that small and large operands both show up
    function automatic operand_t random_operand();
        int       width;
        operand_t value;
        width = $urandom_range(OPERAND_BITS, 1);
        value = operand_t'($urandom);
        return value & (OPERAND_MAX >> (OPERAND_BITS - width));
    endfunction

    task automatic send_random_division();
        operand_t dividend;
        operand_t divisor;
        if ($urandom_range(9) == 0)
            dividend = operand_t'($urandom);
        else
            dividend = random_operand();
        case ($urandom_range(19))
            0:       divisor = '0;
            1:       divisor = OPERAND_MAX;
            2:       divisor = dividend;
            3:       divisor = dividend + 1'b1;
            4:       divisor = operand_t'($urandom);
            default: divisor = random_operand();
        endcase
        send_division(dividend, divisor);
    endtask

    // Zero, one, the top bit and all ones on both operands
    task automatic test_operand_extremes();
        send_division('0, '0);
        send_division('0, 1);
        send_division('0, OPERAND_MAX);
        send_division(OPERAND_MAX, 1);
        send_division(OPERAND_MAX, OPERAND_MAX);
        send_division(1, OPERAND_MAX);
        send_division(1, 1);
        send_division(TOP_BIT, 1);
        send_division(TOP_BIT, TOP_BIT);
        send_division(TOP_BIT - 1'b1, TOP_BIT);
        send_division(OPERAND_MAX, TOP_BIT);
    endtask

    // Zero divisor, dividend below divisor, exact and inexact quotients
    task automatic test_special_cases();
        send_division(OPERAND_MAX, '0);
        send_division(5, '0);
        send_division(1, '0);
        send_division(TOP_BIT, '0);
        send_division(6, 7);
        send_division(28'h5555555, 28'h5555556);
        send_division(3, 4);
        send_division(100, 10);
        send_division(100, 7);
        send_division(28'hAAAAAAA, 28'h5555555);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_random_division();
    endtask

    // Back-to-back requests with both sides always ready
    task automatic test_steady_stream(input int count);
        no_idle = 1'b1;
        repeat (count) send_random_division();
        no_idle = 1'b0;
    endtask

    // Let the divider run dry after every tenth request
    task automatic test_drain_pause(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_random_division();
            if (i % 10 == 9)
                pause_until_drained();
        end
    endtask

    // Result side: compare each quotient, then pick next cycle's ready
    always @(posedge clk)
    begin : check_quotient
        division_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_divisions.size() == 0)
                report_mismatch($sformatf("quotient 0x%0h with no request pending",
                                          result_if.quotient));
            else
            begin
                want = pending_divisions.pop_front();
                if (result_if.quotient !== want.quotient)
                    report_mismatch($sformatf("0x%0h / 0x%0h: quotient 0x%0h, want 0x%0h",
                                              want.dividend, want.divisor,
                                              result_if.quotient, want.quotient));
            end
        end
        // mostly short stalls, now and then one longer than a division
        if (!rst_n)
            result_if.ready <= 1'b0;
        else if (no_idle)
            result_if.ready <= 1'b1;
        else if (result_stall_left > 0)
        begin
            result_stall_left--;
            result_if.ready <= 1'b0;
        end
        else if ($urandom_range(999) == 0)
        begin
            result_stall_left = $urandom_range(2 * DIV_LATENCY, DIV_LATENCY);
            result_if.ready <= 1'b0;
        end
        else
            result_if.ready <= ($urandom_range(99) >= STALL_PERCENT);
    end

    // Watchdog: end the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if ((request_if.valid && request_if.ready) || (result_if.valid && result_if.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        request_if.valid    = 1'b0;
        request_if.dividend = '0;
        request_if.divisor  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_operand_extremes();
        test_special_cases();
        test_random_mix(330);
        test_steady_stream(60);
        test_drain_pause(60);

        pause_until_drained();
        repeat (DIV_LATENCY + 4) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[restoring_divider.f]
+incdir+sv
sv/rd_pkg.sv
sv/rd_if.sv
sv/restoring_divider.sv
dv/tb_top.sv
